FILE: hw/rtl/hmfe_pkg.sv
package hmfe_pkg;

    // one byte on the line to the controller
    typedef logic [7:0] octet_t;

    // most bytes that one input word can cause
    localparam int unsigned MAX_BYTES = 7;
    localparam int unsigned CNT_W     = 3;

    // frame kinds
    localparam logic [1:0] MODE_UNPROTO = 2'd0;
    localparam logic [1:0] MODE_COMMAND = 2'd1;
    localparam logic [1:0] MODE_DATA    = 2'd2;
    localparam logic [1:0] MODE_RAW     = 2'd3;

    // framing and escape codes
    localparam octet_t FEND  = 8'hC0;
    localparam octet_t FESC  = 8'hDB;
    localparam octet_t TFEND = 8'hDC;
    localparam octet_t TFESC = 8'hDD;

    // header characters
    localparam octet_t CHAR_DATA    = 8'h44;  // 'D'
    localparam octet_t CHAR_COMMAND = 8'h43;  // 'C'
    localparam octet_t CHAR_ZERO    = 8'h30;  // '0'
    localparam octet_t CHAR_AT      = 8'h40;  // 'A' - 1

    // byte list built from one input word
    typedef struct packed {
        octet_t [MAX_BYTES-1:0] seq;
        logic   [CNT_W-1:0]     count;
    } burst_t;

endpackage

FILE: hw/rtl/host_mode_frame_encoder.sv
// channel   direction  handshake              payload
// input     in         in_valid / in_ready    mode, channel, data_byte, byte_valid,
//                                             first_byte, last_byte
// output    out        out_valid / out_ready  out_byte, run_last
// config    in         cfg_wr_en              cfg_wr_data (port_number)
//
// one output word per cycle leaves the output register unless out_ready stalls;
// an input word causes zero to seven of them and holds the byte slot until the
// last moves on. the next input word is taken in the cycle its predecessor's last
// byte moves to the output register; a word causing no byte leaves the slot free.
// reset clears the slot and output valid flags and sets port_number to 1.
// a stall on out_ready holds the output register and then the slot and input.
module host_mode_frame_encoder
    import hmfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    input  logic [4:0] channel,
    input  logic [7:0] data_byte,
    input  logic       byte_valid,
    input  logic       first_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    input  logic       cfg_wr_en,
    input  logic [3:0] cfg_wr_data
);

    logic [3:0] port_reg;
    burst_t     burst;
    logic       can_load;
    logic       load;

    // port number register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_reg <= 4'd1;
        end
        else if (cfg_wr_en)
        begin
            port_reg <= cfg_wr_data;
        end
    end

    assign in_ready = can_load;
    assign load     = in_valid && can_load;

    // build the byte list for the incoming word
    hmfe_expand u_expand (
        .mode        (mode),
        .channel     (channel),
        .data_byte   (data_byte),
        .byte_valid  (byte_valid),
        .first_byte  (first_byte),
        .last_byte   (last_byte),
        .port_number (port_reg),
        .burst       (burst)
    );

    // hold the list and send it one byte at a time
    hmfe_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .burst     (burst),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

endmodule

FILE: hw/rtl/hmfe_expand.sv
module hmfe_expand
    import hmfe_pkg::*;
(
    input  logic [1:0] mode,
    input  logic [4:0] channel,
    input  logic [7:0] data_byte,
    input  logic       byte_valid,
    input  logic       first_byte,
    input  logic       last_byte,
    input  logic [3:0] port_number,
    output burst_t     burst
);

    octet_t letter;
    octet_t digit;
    octet_t stream;

    // header characters
    always_comb
    begin
        letter = (mode == MODE_COMMAND) ? CHAR_COMMAND : CHAR_DATA;
        digit  = CHAR_ZERO + {4'b0000, port_number};
        if (mode == MODE_UNPROTO || (mode == MODE_COMMAND && channel == 5'd0))
        begin
            stream = CHAR_ZERO;
        end
        else
        begin
            stream = CHAR_AT + {3'b000, channel};
        end
    end

    // lay out delimiter, header, payload with escapes, closing delimiter
    always_comb
    begin
        logic [CNT_W-1:0] pos;
        pos = '0;
        burst.seq = '0;
        if (first_byte)
        begin
            burst.seq[pos] = FEND;
            pos = pos + 1'b1;
            if (mode != MODE_RAW)
            begin
                burst.seq[pos] = letter;
                pos = pos + 1'b1;
                burst.seq[pos] = digit;
                pos = pos + 1'b1;
                burst.seq[pos] = stream;
                pos = pos + 1'b1;
            end
        end
        if (byte_valid)
        begin
            if (data_byte == FEND || data_byte == FESC)
            begin
                burst.seq[pos] = FESC;
                pos = pos + 1'b1;
                burst.seq[pos] = (data_byte == FEND) ? TFEND : TFESC;
                pos = pos + 1'b1;
            end
            else
            begin
                burst.seq[pos] = data_byte;
                pos = pos + 1'b1;
            end
        end
        if (last_byte)
        begin
            burst.seq[pos] = FEND;
            pos = pos + 1'b1;
        end
        burst.count = pos;
    end

endmodule

FILE: hw/rtl/hmfe_emit.sv
module hmfe_emit
    import hmfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  burst_t     burst,
    output logic       can_load,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last
);

    logic                       slot_valid_reg, slot_valid_next;
    octet_t [MAX_BYTES-1:0]     seq_reg;
    logic   [CNT_W-1:0]         cnt_reg;
    logic   [CNT_W-1:0]         idx_reg, idx_next;
    logic                       out_valid_reg;
    octet_t                     out_byte_reg;
    logic                       run_last_reg;

    logic out_load;
    logic slot_end;

    // move one byte from the slot into the output register when it is free
    assign out_load = slot_valid_reg && (!out_valid_reg || out_ready);
    assign slot_end = (idx_reg == cnt_reg - 1'b1);
    assign can_load = !slot_valid_reg || (out_load && slot_end);

    // slot control
    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        idx_next        = idx_reg;
        if (out_load)
        begin
            idx_next = idx_reg + 1'b1;
            if (slot_end)
            begin
                slot_valid_next = 1'b0;
            end
        end
        if (load)
        begin
            slot_valid_next = (burst.count != '0);
            idx_next        = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            idx_reg        <= idx_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            seq_reg <= burst.seq;
            cnt_reg <= burst.count;
        end
        if (out_load)
        begin
            out_byte_reg <= seq_reg[idx_reg];
            run_last_reg <= slot_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;

endmodule
